// ===== rtl/phong_glossy_specular_brdf_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Phong specular lobe core
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PHONG_GLOSSY_SPECULAR_BRDF_CORE_ASSERT_SVH
`define PHONG_GLOSSY_SPECULAR_BRDF_CORE_ASSERT_SVH

// same-cycle implication
`define PGSB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PGSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pgsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Phong specular lobe package
// Exp2 step constants and the log2 table entry generator.
// ----------------------------------------------------------------------------
package pgsb_pkg;

	localparam int EXP_STEPS = 12;

	// 2^(-2^-j) in Q30, j = 1 .. 12
	localparam logic [29:0] EXP_TAB [EXP_STEPS] = '{
		30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
		30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838386,
		30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135
	};

	// Q16 log2 of (1 + i / 2^bits), truncated, one bit per squaring
	function automatic logic [15:0] log_entry(input int i, input int bits);
		logic [63:0] y;
		logic [15:0] l;
		y = 64'((64'(1) << bits) + 64'(i)) << (30 - bits);
		l = '0;
		for (int b = 0; b < 16; b++) begin
			y = (y * y) >> 30;
			l = {l[14:0], 1'b0};
			if (y >= (64'(1) << 31)) begin
				l[0] = 1'b1;
				y = y >> 1;
			end
		end
		return l;
	endfunction

endpackage

// ===== rtl/phong_glossy_specular_brdf_core.sv =====
// Throughput: one beat per cycle while the output is not stalled; the exp2 chain takes one multiply per stage.
// A stalled output beat holds every stage in place.
// Reset clears all stage valid bits and sets the exponent to 1.0.
// ----------------------------------------------------------------------------
// Phong glossy specular lobe core
// Reflects wi about n, raises r.wo to the exponent via log2/exp2, scales
// by weight and color with saturation.
// ----------------------------------------------------------------------------
`include "phong_glossy_specular_brdf_core_assert.svh"

module phong_glossy_specular_brdf_core #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,      // exponent
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// normal_x, normal_y, normal_z, in_x, in_y, in_z, out_x, out_y, out_z,
	// spec_weight, base_color
	input  logic [207:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata   // radiance_r, radiance_g, radiance_b
);

	localparam int LB  = LOG_TABLE_BITS;
	localparam int NST = 13 + LB;

	typedef struct packed {
		logic             pos;
		logic [2:0][31:0] wc;
	} side_t;

	logic              en;
	logic [NST-1:0]    vld_s;
	logic [15:0]       exponent_q;
	side_t             side_s [NST];

	logic [15:0]       log_lut [2**LB];

	logic signed [15:0] n_s1 [3], wi_s1 [3], wo_s1 [3];
	logic signed [31:0] nw_s1 [3];
	logic signed [15:0] n_s2 [3], wi_s2 [3], wo_s2 [3];
	logic signed [32:0] ndw_s2;
	logic signed [15:0] wi_s3 [3], wo_s3 [3];
	logic signed [49:0] t_s3 [3];
	logic signed [15:0] wo_s4 [3];
	logic signed [36:0] r_s4 [3];
	logic signed [52:0] q_s5 [3];
	logic [42:0]        x_s6, x_s7;
	logic [5:0]         p_s7;
	logic [21:0]        neg_s8;
	logic [37:0]        pr_s9;
	logic [14:0]        k_s10;
	logic [LB-1:0]      f_s10;
	logic [30:0]        m_se [LB+1];
	logic [14:0]        k_se [LB+1];
	logic [LB-1:0]      f_se [LB+1];
	logic [30:0]        pw_s;
	logic [2:0][62:0]   y_s;
	logic [2:0][15:0]   rad_s;

	logic signed [31:0] nw_c [3];
	logic [2:0][31:0]   wc_c;
	logic signed [48:0] np_c [3];
	logic signed [49:0] tsh_c [3];
	logic signed [36:0] r_c [3];
	logic signed [54:0] sum_c;
	logic [5:0]         p_c;
	logic [42+LB:0]     xs_c;
	logic [38:0]        n_c;
	logic [20:0]        v_c [3];

	for (genvar g = 0; g < 2**LB; g++) begin : g_lut
		localparam logic [15:0] LV = pgsb_pkg::log_entry(g, LB);
		assign log_lut[g] = LV;
	end

	assign en            = !vld_s[NST-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = vld_s[NST-1];
	assign m_axis_tdata  = {rad_s[2], rad_s[1], rad_s[0]};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw_c[i] = $signed(s_axis_tdata[16*i +: 16]) * $signed(s_axis_tdata[48+16*i +: 16]);
			wc_c[i] = 32'(s_axis_tdata[159:144]) * 32'(s_axis_tdata[192-16*i +: 16]);
			np_c[i] = n_s2[i] * ndw_s2;
			tsh_c[i] = t_s3[i] >>> 14;
			r_c[i] = tsh_c[i][36:0] - {{7{wi_s3[i][15]}}, wi_s3[i], 14'd0};
			v_c[i] = y_s[i][62:42];
		end
		sum_c = q_s5[0] + q_s5[1] + q_s5[2];
		p_c = '0;
		for (int b = 0; b < 43; b++) begin
			if (x_s6[b]) p_c = 6'(b);
		end
		xs_c = {x_s7, {LB{1'b0}}} >> p_s7;
		n_c  = 39'(pr_s9) + 39'd255;
	end

	assign m_se[0] = 31'd1 << 30;
	assign k_se[0] = k_s10;
	assign f_se[0] = f_s10;

	for (genvar j = 1; j <= LB; j++) begin : g_exp
		logic [61:0] mp_c;
		assign mp_c = 62'(m_se[j-1]) * 62'(pgsb_pkg::EXP_TAB[j-1]) + (62'd1 << 29);
		always_ff @(posedge clk) begin
			if (en) begin
				m_se[j] <= f_se[j-1][LB-j] ? mp_c[60:30] : m_se[j-1];
				k_se[j] <= k_se[j-1];
				f_se[j] <= f_se[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s      <= '0;
			exponent_q <= 16'd256;
		end else begin
			if (cfg_valid) exponent_q <= cfg_data;
			if (en) vld_s <= {vld_s[NST-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0].pos <= 1'b0;
			side_s[0].wc  <= wc_c;
			for (int s = 1; s < NST; s++) begin
				if (s != 5) side_s[s] <= side_s[s-1];
			end
			side_s[5].wc  <= side_s[4].wc;
			side_s[5].pos <= (sum_c > 55'sd0);
			for (int i = 0; i < 3; i++) begin
				n_s1[i]  <= s_axis_tdata[16*i +: 16];
				wi_s1[i] <= s_axis_tdata[48+16*i +: 16];
				wo_s1[i] <= s_axis_tdata[96+16*i +: 16];
				nw_s1[i] <= nw_c[i];
				n_s2[i]  <= n_s1[i];
				wi_s2[i] <= wi_s1[i];
				wo_s2[i] <= wo_s1[i];
				wi_s3[i] <= wi_s2[i];
				wo_s3[i] <= wo_s2[i];
				t_s3[i]  <= {np_c[i], 1'b0};
				wo_s4[i] <= wo_s3[i];
				r_s4[i]  <= r_c[i];
				q_s5[i]  <= r_s4[i] * wo_s4[i];
				y_s[i]   <= 63'(side_s[NST-3].wc[i]) * 63'(pw_s) + (63'd1 << 41);
				if (!side_s[NST-2].pos) rad_s[i] <= '0;
				else if (v_c[i] > 21'hFFFF) rad_s[i] <= 16'hFFFF;
				else rad_s[i] <= v_c[i][15:0];
			end
			ndw_s2 <= 33'(nw_s1[0]) + 33'(nw_s1[1]) + 33'(nw_s1[2]);
			if (sum_c > (55'sd1 <<< 42)) x_s6 <= 43'd1 << 42;
			else x_s6 <= sum_c[42:0];
			x_s7   <= x_s6;
			p_s7   <= p_c;
			neg_s8 <= (22'(6'd42 - p_s7) << 16) - 22'(log_lut[xs_c[LB-1:0]]);
			pr_s9  <= 38'(exponent_q) * 38'(neg_s8);
			k_s10  <= n_c[38:24];
			f_s10  <= n_c[23:24-LB];
			pw_s   <= (k_se[LB] > 15'd30) ? 31'd0 : (m_se[LB] >> k_se[LB][4:0]);
		end
	end

	`PGSB_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld_s[0],
		"accepted beat did not enter the first stage")
	`PGSB_ASSERT_NEXT(a_hold, vld_s[NST-1] && !m_axis_tready, $stable(vld_s),
		"pipeline moved while the output beat was stalled")
	`PGSB_ASSERT_NOW(a_ready, !vld_s[NST-1], s_axis_tready,
		"input blocked with an empty output stage")

endmodule
